### design/dsrt_pkg.sv
// Shared types, operation and status codes for the deque search and replace table.
package dsrt_pkg;

  localparam int DATA_W       = 32;
  localparam int OP_W         = 3;
  localparam int ST_W         = 2;
  localparam int IDX_W        = 4;
  localparam int CNT_W        = 5;
  localparam int DEF_CAPACITY = 16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD_HEAD    = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE_TAIL = 3'd1;
  localparam logic [OP_W-1:0] OP_SEARCH_HEAD = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH_TAIL = 3'd3;
  localparam logic [OP_W-1:0] OP_REPLACE     = 3'd4;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] found_index;
    logic [CNT_W-1:0] entry_count;
  } rsp_t;

  // Commands broadcast from the controller to every cell.
  typedef struct packed {
    logic push;        // shift entries one place toward the tail
    logic capture;     // load the compare result into the match flag
    logic shift_head;  // move match flags one place toward the head
    logic shift_tail;  // move match flags one place toward the tail
    logic write;       // write the replacement value into the selected cell
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

### design/deque_search_replace_table_top.sv
// Top level of the deque search and replace table: cell chain and controller.
//
// Requests arrive on req/req_valid/req_stall and results leave on
// rsp/rsp_valid/rsp_stall; a transfer happens when valid is high and stall is
// low. Every request gives exactly one result.
// Add at head, remove at tail, and requests that fail at once (empty, full,
// unknown code) give their result through the output register, and a new
// request can be taken every cycle while the result side keeps up.
// Searches and replace first compare every cell, then hand the match flags
// along the cell chain one place per cycle toward the scanned end; a match
// gives its result when its flag reaches the cell at that end, a miss once
// the last occupied cell has been reached without a hit.
// req_stall is high while a scan runs.
// The result sits in an output register; a new request is taken while it
// waits. If a second result is ready while the first is still stalled, the
// block holds it and raises req_stall until rsp is taken.
// Reset clears the entry count and empties the output register; entry
// contents are not cleared and are never read before written.
module deque_search_replace_table_top
  import dsrt_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
)(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [IW-1:0]     step, step_next;
  logic [OP_W-1:0]   op_q, op_next;
  logic [DATA_W-1:0] nv;
  rsp_t              res, res_next;
  rsp_t              rsp_next;
  logic              rsp_valid_next;
  cell_ctrl_t        ctrl;

  logic [DATA_W-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] tail_mark;

  logic              accept;
  logic              out_free;
  logic              hit;
  logic              fin;
  rsp_t              fin_res;
  logic [CW+CNT_W-1:0] cnt_ext;
  logic [IW+IDX_W-1:0] idx_ext;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // Cell chain.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] e_prev;
    logic              m_prev;
    logic              m_next;

    if (i == 0) begin : g_head
      assign e_prev = req.value;
      assign m_prev = 1'b0;
    end else begin : g_mid
      assign e_prev = entry[i-1];
      assign m_prev = match[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign m_next = 1'b0;
    end else begin : g_body
      assign m_next = match[i+1];
    end

    assign tail_mark[i] = (count == CW'(i + 1));

    dsrt_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .entry_prev (e_prev),
      .match_prev (m_prev),
      .match_next (m_next),
      .key        (req.value),
      .wdata      (nv),
      .occupied   (count > CW'(i)),
      .sel        (step == IW'(i)),
      .entry      (entry[i]),
      .match      (match[i])
    );
  end

  // Hit at the scanned end: cell 0 for head scans, the tail cell for tail scans.
  assign hit = (op_q == OP_SEARCH_TAIL) ? |(match & tail_mark) : match[0];

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Payload and scan registers.
  always_ff @(posedge clk) begin
    step <= step_next;
    op_q <= op_next;
    res  <= res_next;
    rsp  <= rsp_next;
    if (ctrl.capture) begin
      nv <= req.new_value;
    end
  end

  // Next state, cell commands and result.
  always_comb begin
    state_next     = state;
    count_next     = count;
    step_next      = step;
    op_next        = op_q;
    res_next       = res;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    ctrl           = '0;
    fin            = 1'b0;
    fin_res.status = ST_OK;
    idx_ext        = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.operation) inside
            OP_ADD_HEAD: begin
              fin = 1'b1;
              if (count == CW'(CAPACITY)) begin
                fin_res.status = ST_FULL;
              end else begin
                ctrl.push  = 1'b1;
                count_next = count + CW'(1);
              end
            end
            OP_REMOVE_TAIL: begin
              fin = 1'b1;
              if (count == '0) begin
                fin_res.status = ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
              end
            end
            OP_SEARCH_HEAD, OP_SEARCH_TAIL, OP_REPLACE: begin
              if (count == '0) begin
                fin            = 1'b1;
                fin_res.status = ST_EMPTY;
              end else begin
                ctrl.capture = 1'b1;
                step_next    = '0;
                op_next      = req.operation;
                state_next   = S_SCAN;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          fin = 1'b1;
          if (op_q == OP_REPLACE) begin
            ctrl.write = 1'b1;
          end else begin
            idx_ext = (IW + IDX_W)'(step);
          end
        end else if (CW'(step) + CW'(1) == count) begin
          fin            = 1'b1;
          fin_res.status = ST_NOTFOUND;
        end else begin
          step_next       = step + IW'(1);
          ctrl.shift_head = (op_q != OP_SEARCH_TAIL);
          ctrl.shift_tail = (op_q == OP_SEARCH_TAIL);
        end
      end
      S_DONE: begin
        if (out_free) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    cnt_ext             = (CW + CNT_W)'(count_next);
    fin_res.found_index = idx_ext[IDX_W-1:0];
    fin_res.entry_count = cnt_ext[CNT_W-1:0];

    // Hand a finished result to the output register, or hold it if that is busy.
    if (fin) begin
      if (out_free) begin
        rsp_next       = fin_res;
        rsp_valid_next = 1'b1;
        state_next     = S_IDLE;
      end else begin
        res_next   = fin_res;
        state_next = S_DONE;
      end
    end
  end

  // The entry count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A scan never looks past the last occupied cell.
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> CW'(step) < count)
    else $error("scan step beyond list length");

  // An accepted insert into a list with room grows the count by one.
  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    accept && req.operation == OP_ADD_HEAD && count != CW'(CAPACITY)
    |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the list");

  // A held result only exists while the output register is occupied.
  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> rsp_valid)
    else $error("result held while output register empty");

endmodule

### design/dsrt_cell.sv
// One list cell: holds an entry and a match flag, both passed along the chain.
module dsrt_cell
  import dsrt_pkg::*;
(
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] entry_prev,   // entry of the neighbor nearer the head
  input  logic              match_prev,   // match flag of the neighbor nearer the head
  input  logic              match_next,   // match flag of the neighbor nearer the tail
  input  logic [DATA_W-1:0] key,
  input  logic [DATA_W-1:0] wdata,
  input  logic              occupied,
  input  logic              sel,
  output logic [DATA_W-1:0] entry,
  output logic              match
);

  // Entry storage: take the neighbor's value on a push, or the new value on a replace.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entry <= entry_prev;
    end else if (ctrl.write && sel) begin
      entry <= wdata;
    end
  end

  // Match flag: local compare, then handed along the chain one cell per cycle.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      match <= occupied && (entry == key);
    end else if (ctrl.shift_head) begin
      match <= match_next;
    end else if (ctrl.shift_tail) begin
      match <= match_prev;
    end
  end

endmodule
